/* rtl/core/sscl_pkg.sv */
`timescale 1ns / 1ps

package sscl_pkg;

   localparam int COMPONENT_BITS_DEF     = 21;
   localparam int TIME_FRACTION_BITS_DEF = 16;

   localparam int WORD_W    = 63;
   localparam int DIST_W    = 21;
   localparam int HORIZON_W = 31;
   localparam int TOL_W     = 16;
   localparam int TIME_W    = 32;

   localparam int DIFF_W = 22;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int A_W    = 44;
   localparam int H_W    = 46;
   localparam int C_W    = 46;
   localparam int MAG_W  = 44;
   localparam int HALF_W = MAG_W / 2;
   localparam int ROOT_W = 45;
   localparam int DISC_W = 2 * ROOT_W;
   localparam int NUM_W  = 47;
   localparam int QUO_W  = 33;

   localparam logic [1:0] OUTCOME_NONE     = 2'd0;
   localparam logic [1:0] OUTCOME_OVERLAP  = 2'd1;
   localparam logic [1:0] OUTCOME_INTERVAL = 2'd2;

   localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W - 1){1'b1}}};
   localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W - 1){1'b0}}};

   typedef struct packed {
      logic [WORD_W-1:0]    first_position;
      logic [WORD_W-1:0]    first_velocity;
      logic [WORD_W-1:0]    second_position;
      logic [WORD_W-1:0]    second_velocity;
      logic [DIST_W-1:0]    contact_distance;
      logic [HORIZON_W-1:0] time_horizon;
   } req_type;

   typedef struct packed {
      logic [1:0]               outcome;
      logic signed [TIME_W-1:0] start_time;
      logic signed [TIME_W-1:0] end_time;
      logic signed [TIME_W-1:0] contact_time;
      logic                     hits_within_horizon;
   } rsp_type;

   typedef struct packed {
      logic                  degenerate;
      logic                  gt_tol;
      logic signed [H_W-1:0] h;
      logic [A_W-1:0]        a;
      logic [HORIZON_W-1:0]  horizon;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic [DISC_W-1:0] disc;
   } front_type;

   typedef struct packed {
      logic                 degenerate;
      logic                 gt_tol;
      logic [HORIZON_W-1:0] horizon;
   } div_tag_type;

endpackage

/* rtl/core/swept_sphere_collision_interval.sv */
`timescale 1ns / 1ps
// Stages from start to rsp_strobe, in order: front end, square root, numerator, divide and
//   output stage.
// Throughput: one item per cycle; busy stays low and every stage advances each cycle.
// Synchronous active-high reset clears all stage valid bits and sets the tolerance register tol_ff to 1.
// rsp_strobe is high for one cycle per item; the receiver cannot stall the pipeline.
module swept_sphere_collision_interval #(
   parameter int COMPONENT_BITS     = sscl_pkg::COMPONENT_BITS_DEF,
   parameter int TIME_FRACTION_BITS = sscl_pkg::TIME_FRACTION_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  sscl_pkg::req_type           req_payload,
   output logic                        rsp_strobe,
   output sscl_pkg::rsp_type           rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sscl_pkg::TOL_W-1:0]  csr_data
);
   import sscl_pkg::*;

   logic [TOL_W-1:0] tol_ff;

   logic        fr_vld;
   front_type   fr;
   logic        sq_vld;
   logic [ROOT_W-1:0] sq_root;
   logic [$bits(tag_type)-1:0] sq_tag_raw;
   tag_type     sq_tag;

   logic signed [NUM_W-1:0] num_ff [2];
   logic [A_W-1:0]          den_ff;
   div_tag_type             ntag_ff;
   logic                    nvld_ff;

   logic                           dv_vld;
   logic signed [TIME_W-1:0]       dv_time [2];
   logic [$bits(div_tag_type)-1:0] dv_tag_raw;
   div_tag_type                    dv_tag;

   logic                     strobe_ff;
   rsp_type                  rsp_in, rsp_ff;
   logic signed [TIME_W-1:0] first;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   sscl_front #(
      .COMPONENT_BITS(COMPONENT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (start & ~busy),
      .in_req    (req_payload),
      .tol       (tol_ff),
      .out_vld   (fr_vld),
      .out_front (fr)
   );

   sscl_isqrt #(
      .TAG_W($bits(tag_type))
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (fr_vld),
      .in_rad   (fr.disc),
      .in_tag   (fr.tag),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_tag  (sq_tag_raw)
   );

   assign sq_tag = tag_type'(sq_tag_raw);

   always_ff @(posedge clock) begin
      num_ff[0]          <= -NUM_W'(sq_tag.h) - $signed(NUM_W'(sq_root));
      num_ff[1]          <= -NUM_W'(sq_tag.h) + $signed(NUM_W'(sq_root));
      den_ff             <= sq_tag.a;
      ntag_ff.degenerate <= sq_tag.degenerate;
      ntag_ff.gt_tol     <= sq_tag.gt_tol;
      ntag_ff.horizon    <= sq_tag.horizon;
      if (reset) begin
         nvld_ff <= 1'b0;
      end else begin
         nvld_ff <= sq_vld;
      end
   end

   sscl_tdiv #(
      .TIME_FRACTION_BITS(TIME_FRACTION_BITS),
      .TAG_W             ($bits(div_tag_type))
   ) u_tdiv (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (nvld_ff),
      .in_num   (num_ff),
      .in_den   (den_ff),
      .in_tag   (ntag_ff),
      .out_vld  (dv_vld),
      .out_time (dv_time),
      .out_tag  (dv_tag_raw)
   );

   assign dv_tag = div_tag_type'(dv_tag_raw);

   always_comb begin
      first = dv_time[0][TIME_W-1] ? '0 : dv_time[0];
      if (dv_tag.degenerate) begin
         if (dv_tag.gt_tol) begin
            rsp_in.outcome             = OUTCOME_NONE;
            rsp_in.start_time          = '0;
            rsp_in.end_time            = '0;
            rsp_in.contact_time        = -$signed(TIME_W'(1) << TIME_FRACTION_BITS);
            rsp_in.hits_within_horizon = 1'b0;
         end else begin
            rsp_in.outcome             = OUTCOME_OVERLAP;
            rsp_in.start_time          = '0;
            rsp_in.end_time            = $signed(TIME_MAX);
            rsp_in.contact_time        = '0;
            rsp_in.hits_within_horizon = 1'b1;
         end
      end else begin
         rsp_in.outcome    = OUTCOME_INTERVAL;
         rsp_in.start_time = dv_time[0];
         rsp_in.end_time   = dv_time[1];
         if (dv_time[1][TIME_W-1]) begin
            rsp_in.contact_time = dv_time[1];
         end else if (dv_time[0][TIME_W-1]) begin
            rsp_in.contact_time = '0;
         end else begin
            rsp_in.contact_time = dv_time[0];
         end
         rsp_in.hits_within_horizon = !dv_time[1][TIME_W-1]
                                   && ($unsigned(first) <= TIME_W'(dv_tag.horizon));
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_vld;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/core/sscl_front.sv */
`timescale 1ns / 1ps

module sscl_front #(
   parameter int COMPONENT_BITS = sscl_pkg::COMPONENT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_vld,
   input  sscl_pkg::req_type           in_req,
   input  logic [sscl_pkg::TOL_W-1:0]  tol,
   output logic                        out_vld,
   output sscl_pkg::front_type         out_front
);
   import sscl_pkg::*;

   localparam int CB = COMPONENT_BITS;

   function automatic logic signed [DIFF_W-1:0] comp(input logic [WORD_W-1:0] w, input int idx);
      logic [CB-1:0] raw;
      raw = w[idx*CB +: CB];
      return {{(DIFF_W - CB){raw[CB-1]}}, raw};
   endfunction

   logic [6:0] vld_ff;

   logic signed [DIFF_W-1:0] p1_in [3], v1_in [3], p1_ff [3], v1_ff [3];
   logic [DIST_W-1:0]        dd1_ff;
   logic [HORIZON_W-1:0]     hz1_ff, hz2_ff, hz3_ff, hz4_ff, hz5_ff, hz6_ff, hz7_ff;

   logic signed [PROD_W-1:0] pp2_ff [3], pv2_ff [3], vv2_ff [3];
   logic [PROD_W-1:0]        dd2_ff;

   logic [A_W-1:0]        a3_ff, a4_ff, a5_ff, a6_ff, a7_ff;
   logic signed [H_W-1:0] h3_ff, h4_ff, h5_ff, h6_ff, h7_ff;
   logic signed [C_W-1:0] c3_in, c3_ff;

   logic [MAG_W-1:0] hm4_ff, cm4_ff;
   logic             cneg4_ff, cneg5_ff, cneg6_ff;
   logic             gt4_ff, gt5_ff, gt6_ff, gt7_ff;
   logic             az4_ff, az5_ff, az6_ff;

   logic [PROD_W-1:0] hh_part_ff [3];
   logic [PROD_W-1:0] ac_part_ff [4];

   logic [DISC_W-1:0] hh6_ff, ac6_ff;
   logic [DISC_W-1:0] disc7_in, disc7_ff;
   logic              deg7_in, deg7_ff;
   logic              dneg;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[5:0], in_vld};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_in[i] = comp(in_req.first_position, i) - comp(in_req.second_position, i);
         v1_in[i] = comp(in_req.first_velocity, i) - comp(in_req.second_velocity, i);
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      v1_ff  <= v1_in;
      dd1_ff <= in_req.contact_distance;
      hz1_ff <= in_req.time_horizon;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pp2_ff[i] <= p1_ff[i] * p1_ff[i];
         pv2_ff[i] <= p1_ff[i] * v1_ff[i];
         vv2_ff[i] <= v1_ff[i] * v1_ff[i];
      end
      dd2_ff <= PROD_W'(dd1_ff) * PROD_W'(dd1_ff);
      hz2_ff <= hz1_ff;
   end

   always_comb begin
      c3_in = C_W'(pp2_ff[0]) + C_W'(pp2_ff[1]) + C_W'(pp2_ff[2])
            - $signed({{(C_W - PROD_W){1'b0}}, dd2_ff});
   end

   always_ff @(posedge clock) begin
      a3_ff  <= A_W'($unsigned(vv2_ff[0])) + A_W'($unsigned(vv2_ff[1]))
              + A_W'($unsigned(vv2_ff[2]));
      h3_ff  <= H_W'(pv2_ff[0]) + H_W'(pv2_ff[1]) + H_W'(pv2_ff[2]);
      c3_ff  <= c3_in;
      hz3_ff <= hz2_ff;
   end

   always_ff @(posedge clock) begin
      hm4_ff   <= h3_ff[H_W-1] ? MAG_W'(-h3_ff) : MAG_W'(h3_ff);
      cm4_ff   <= c3_ff[C_W-1] ? MAG_W'(-c3_ff) : MAG_W'(c3_ff);
      cneg4_ff <= c3_ff[C_W-1];
      gt4_ff   <= c3_ff > $signed({{(C_W - TOL_W){1'b0}}, tol});
      az4_ff   <= (a3_ff == '0);
      a4_ff    <= a3_ff;
      h4_ff    <= h3_ff;
      hz4_ff   <= hz3_ff;
   end

   always_ff @(posedge clock) begin
      hh_part_ff[0] <= PROD_W'(hm4_ff[MAG_W-1:HALF_W]) * PROD_W'(hm4_ff[MAG_W-1:HALF_W]);
      hh_part_ff[1] <= PROD_W'(hm4_ff[MAG_W-1:HALF_W]) * PROD_W'(hm4_ff[HALF_W-1:0]);
      hh_part_ff[2] <= PROD_W'(hm4_ff[HALF_W-1:0]) * PROD_W'(hm4_ff[HALF_W-1:0]);
      ac_part_ff[0] <= PROD_W'(a4_ff[A_W-1:HALF_W]) * PROD_W'(cm4_ff[MAG_W-1:HALF_W]);
      ac_part_ff[1] <= PROD_W'(a4_ff[A_W-1:HALF_W]) * PROD_W'(cm4_ff[HALF_W-1:0]);
      ac_part_ff[2] <= PROD_W'(a4_ff[HALF_W-1:0]) * PROD_W'(cm4_ff[MAG_W-1:HALF_W]);
      ac_part_ff[3] <= PROD_W'(a4_ff[HALF_W-1:0]) * PROD_W'(cm4_ff[HALF_W-1:0]);
      cneg5_ff <= cneg4_ff;
      gt5_ff   <= gt4_ff;
      az5_ff   <= az4_ff;
      a5_ff    <= a4_ff;
      h5_ff    <= h4_ff;
      hz5_ff   <= hz4_ff;
   end

   always_ff @(posedge clock) begin
      hh6_ff <= (DISC_W'(hh_part_ff[0]) << (2 * HALF_W))
              + (DISC_W'(hh_part_ff[1]) << (HALF_W + 1))
              + DISC_W'(hh_part_ff[2]);
      ac6_ff <= (DISC_W'(ac_part_ff[0]) << (2 * HALF_W))
              + ((DISC_W'(ac_part_ff[1]) + DISC_W'(ac_part_ff[2])) << HALF_W)
              + DISC_W'(ac_part_ff[3]);
      cneg6_ff <= cneg5_ff;
      gt6_ff   <= gt5_ff;
      az6_ff   <= az5_ff;
      a6_ff    <= a5_ff;
      h6_ff    <= h5_ff;
      hz6_ff   <= hz5_ff;
   end

   always_comb begin
      dneg = 1'b0;
      if (cneg6_ff) begin
         disc7_in = hh6_ff + ac6_ff;
      end else if (hh6_ff < ac6_ff) begin
         dneg     = 1'b1;
         disc7_in = hh6_ff;
      end else begin
         disc7_in = hh6_ff - ac6_ff;
      end
      deg7_in = dneg | az6_ff;
   end

   always_ff @(posedge clock) begin
      disc7_ff <= disc7_in;
      deg7_ff  <= deg7_in;
      gt7_ff   <= gt6_ff;
      a7_ff    <= a6_ff;
      h7_ff    <= h6_ff;
      hz7_ff   <= hz6_ff;
   end

   assign out_vld                  = vld_ff[6];
   assign out_front.disc           = disc7_ff;
   assign out_front.tag.degenerate = deg7_ff;
   assign out_front.tag.gt_tol     = gt7_ff;
   assign out_front.tag.h          = h7_ff;
   assign out_front.tag.a          = a7_ff;
   assign out_front.tag.horizon    = hz7_ff;

endmodule

/* rtl/core/sscl_isqrt.sv */
`timescale 1ns / 1ps

module sscl_isqrt #(
   parameter int TAG_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_vld,
   input  logic [sscl_pkg::DISC_W-1:0]  in_rad,
   input  logic [TAG_W-1:0]             in_tag,
   output logic                         out_vld,
   output logic [sscl_pkg::ROOT_W-1:0]  out_root,
   output logic [TAG_W-1:0]             out_tag
);
   import sscl_pkg::*;

   localparam int REM_W = DISC_W + 1;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W];
   logic              vld_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int K = ROOT_W - 1 - i;

      logic [REM_W-1:0]  rem_prev, trial, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [TAG_W-1:0]  tag_prev;
      logic              vld_prev;

      if (i == 0) begin : g_head
         assign rem_prev  = REM_W'(in_rad);
         assign root_prev = '0;
         assign tag_prev  = in_tag;
         assign vld_prev  = in_vld;
      end else begin : g_tail
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign tag_prev  = tag_ff[i-1];
         assign vld_prev  = vld_ff[i-1];
      end

      always_comb begin
         trial   = (REM_W'(root_prev) << (K + 1)) | (REM_W'(1) << (2 * K));
         rem_in  = rem_prev;
         root_in = root_prev;
         if (rem_prev >= trial) begin
            rem_in     = rem_prev - trial;
            root_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         tag_ff[i]  <= tag_prev;
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_tag  = tag_ff[ROOT_W-1];

endmodule

/* rtl/core/sscl_tdiv.sv */
`timescale 1ns / 1ps

module sscl_tdiv #(
   parameter int TIME_FRACTION_BITS = sscl_pkg::TIME_FRACTION_BITS_DEF,
   parameter int TAG_W              = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_vld,
   input  logic signed [sscl_pkg::NUM_W-1:0]   in_num [2],
   input  logic [sscl_pkg::A_W-1:0]            in_den,
   input  logic [TAG_W-1:0]                    in_tag,
   output logic                                out_vld,
   output logic signed [sscl_pkg::TIME_W-1:0]  out_time [2],
   output logic [TAG_W-1:0]                    out_tag
);
   import sscl_pkg::*;

   localparam int MAG_N = NUM_W - 1;
   localparam int NW    = MAG_N + TIME_FRACTION_BITS;
   localparam int REM_W = A_W + QUO_W;
   localparam int CMP_W = (NW > REM_W) ? NW : REM_W;
   localparam int L     = QUO_W - 1;

   // sign and magnitude
   logic [MAG_N-1:0] mag_a_ff [2];
   logic             neg_a_ff [2];
   logic [A_W-1:0]   den_a_ff;
   logic [TAG_W-1:0] tag_a_ff;
   logic             vld_a_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 2; j++) begin
         neg_a_ff[j] <= in_num[j][NUM_W-1];
         mag_a_ff[j] <= in_num[j][NUM_W-1] ? MAG_N'(-in_num[j]) : MAG_N'(in_num[j]);
      end
      den_a_ff <= in_den;
      tag_a_ff <= in_tag;
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_vld;
      end
   end

   // overflow check and scaling
   logic [CMP_W-1:0] num_ext [2];
   logic [CMP_W-1:0] lim;
   logic [REM_W-1:0] rem_b_in [2], rem_b_ff [2];
   logic             sat_b_in [2], sat_b_ff [2], neg_b_ff [2];
   logic [A_W-1:0]   den_b_ff;
   logic [TAG_W-1:0] tag_b_ff;
   logic             vld_b_ff;

   always_comb begin
      lim = CMP_W'(den_a_ff) << QUO_W;
      for (int j = 0; j < 2; j++) begin
         num_ext[j]  = CMP_W'(mag_a_ff[j]) << TIME_FRACTION_BITS;
         sat_b_in[j] = num_ext[j] >= lim;
         rem_b_in[j] = num_ext[j][REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_b_ff <= rem_b_in;
      sat_b_ff <= sat_b_in;
      neg_b_ff <= neg_a_ff;
      den_b_ff <= den_a_ff;
      tag_b_ff <= tag_a_ff;
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else begin
         vld_b_ff <= vld_a_ff;
      end
   end

   // one quotient bit per stage
   logic [REM_W-1:0] rem_ff [QUO_W][2];
   logic [QUO_W-1:0] q_ff   [QUO_W][2];
   logic             sat_ff [QUO_W][2];
   logic             neg_ff [QUO_W][2];
   logic [A_W-1:0]   den_ff [QUO_W];
   logic [TAG_W-1:0] tag_ff [QUO_W];
   logic             vld_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int K = QUO_W - 1 - i;

      logic [REM_W-1:0] rem_prev [2];
      logic [QUO_W-1:0] q_prev [2];
      logic             sat_prev [2];
      logic             neg_prev [2];
      logic [A_W-1:0]   den_prev;
      logic [TAG_W-1:0] tag_prev;
      logic             vld_prev;
      logic [REM_W-1:0] step;
      logic [REM_W-1:0] rem_in [2];
      logic [QUO_W-1:0] q_in [2];

      if (i == 0) begin : g_head
         assign rem_prev = rem_b_ff;
         assign q_prev   = '{'0, '0};
         assign sat_prev = sat_b_ff;
         assign neg_prev = neg_b_ff;
         assign den_prev = den_b_ff;
         assign tag_prev = tag_b_ff;
         assign vld_prev = vld_b_ff;
      end else begin : g_tail
         assign rem_prev = rem_ff[i-1];
         assign q_prev   = q_ff[i-1];
         assign sat_prev = sat_ff[i-1];
         assign neg_prev = neg_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign tag_prev = tag_ff[i-1];
         assign vld_prev = vld_ff[i-1];
      end

      always_comb begin
         step = REM_W'(den_prev) << K;
         for (int j = 0; j < 2; j++) begin
            rem_in[j] = rem_prev[j];
            q_in[j]   = q_prev[j];
            if (rem_prev[j] >= step) begin
               rem_in[j]  = rem_prev[j] - step;
               q_in[j][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         q_ff[i]   <= q_in;
         sat_ff[i] <= sat_prev;
         neg_ff[i] <= neg_prev;
         den_ff[i] <= den_prev;
         tag_ff[i] <= tag_prev;
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
      end
   end

   // round toward minus infinity and saturate
   logic [QUO_W:0]           up_mag [2];
   logic signed [TIME_W-1:0] time_in [2], time_ff [2];
   logic [TAG_W-1:0]         tag_o_ff;
   logic                     vld_o_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         up_mag[j] = {1'b0, q_ff[L][j]} + (QUO_W + 1)'(|rem_ff[L][j]);
         if (!neg_ff[L][j]) begin
            if (sat_ff[L][j] || (q_ff[L][j] > QUO_W'(TIME_MAX))) begin
               time_in[j] = $signed(TIME_MAX);
            end else begin
               time_in[j] = $signed(TIME_W'(q_ff[L][j]));
            end
         end else begin
            if (sat_ff[L][j] || (up_mag[j] > (QUO_W + 1)'(TIME_MIN))) begin
               time_in[j] = $signed(TIME_MIN);
            end else begin
               time_in[j] = -$signed(TIME_W'(up_mag[j]));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      time_ff  <= time_in;
      tag_o_ff <= tag_ff[L];
      if (reset) begin
         vld_o_ff <= 1'b0;
      end else begin
         vld_o_ff <= vld_ff[L];
      end
   end

   assign out_vld  = vld_o_ff;
   assign out_time = time_ff;
   assign out_tag  = tag_o_ff;

endmodule

/* rtl/core/sscl_checker.sv */
`timescale 1ns / 1ps

module sscl_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_strobe,
   input sscl_pkg::rsp_type rsp_payload
);
   import sscl_pkg::*;

   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe straight after reset");

   a_none_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.outcome == OUTCOME_NONE) |->
         (rsp_payload.start_time == '0 && rsp_payload.end_time == '0
          && !rsp_payload.hits_within_horizon))
      else $error("no-contact item with non-zero times or hit flag");

   a_overlap_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.outcome == OUTCOME_OVERLAP) |->
         (rsp_payload.start_time == '0 && rsp_payload.end_time == $signed(TIME_MAX)
          && rsp_payload.contact_time == '0 && rsp_payload.hits_within_horizon))
      else $error("overlap item with wrong fields");

   a_interval_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.outcome == OUTCOME_INTERVAL) |->
         (rsp_payload.start_time <= rsp_payload.end_time))
      else $error("interval start after end");

endmodule

bind swept_sphere_collision_interval sscl_checker u_checker (.*);

/* tb/swept_sphere_collision_interval_tb.sv */
`timescale 1ns / 1ps

module swept_sphere_collision_interval_tb;
   import sscl_pkg::*;

   localparam int FRAC = 16;
   localparam int CB = 21;
   localparam longint TMAX = 64'sd2147483647;
   localparam longint TMIN = -64'sd2147483648;
   localparam int LATENCY = 90;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_strobe;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TOL_W-1:0] csr_data = '0;

   logic [TOL_W-1:0] tolerance;
   rsp_type contact_queue[$];
   int mismatches = 0;
   longint cycles = 0;
   int burst_left = 0;

   swept_sphere_collision_interval dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("swept_sphere_collision_interval_tb NOT OK");
         $finish;
      end
   end

   function automatic longint comp(input logic [WORD_W-1:0] w, input int i);
      logic signed [CB-1:0] r;
      r = w[i*CB +: CB];
      return longint'(r);
   endfunction

   // floor(num * 2^FRAC / den), saturated
   function automatic longint scaled_quotient(input longint num, input longint den);
      logic signed [127:0] n, q, d;
      n = 128'(signed'(num)) <<< FRAC;
      d = 128'(signed'(den));
      q = n / d;
      if (q * d != n && n < 0) q = q - 1;
      if (q > TMAX) return TMAX;
      if (q < TMIN) return TMIN;
      return longint'(q);
   endfunction

   function automatic logic [127:0] int_sqrt(input logic [127:0] v);
      logic [127:0] root, cand;
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (128'd1 << b);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   function automatic rsp_type predict_contact(input req_type rq);
      rsp_type r;
      longint a, h, c, p, v, dd, s, st, en, first;
      logic signed [127:0] disc;
      a = 0; h = 0; c = 0;
      for (int i = 0; i < 3; i++) begin
         p = comp(rq.first_position, i) - comp(rq.second_position, i);
         v = comp(rq.first_velocity, i) - comp(rq.second_velocity, i);
         a += v * v;
         h += p * v;
         c += p * p;
      end
      dd = longint'(rq.contact_distance);
      c = c - dd * dd;
      disc = 128'(signed'(h)) * 128'(signed'(h)) - 128'(signed'(a)) * 128'(signed'(c));
      r = '0;
      if (disc < 0 || a == 0) begin
         if (c > longint'(tolerance)) begin
            r.outcome = OUTCOME_NONE;
            r.contact_time = -(32'sd1 <<< FRAC);
         end else begin
            r.outcome = OUTCOME_OVERLAP;
            r.end_time = TIME_MAX;
            r.hits_within_horizon = 1'b1;
         end
      end else begin
         s = longint'(int_sqrt(disc));
         st = scaled_quotient(-h - s, a);
         en = scaled_quotient(-h + s, a);
         r.outcome = OUTCOME_INTERVAL;
         r.start_time = st[31:0];
         r.end_time = en[31:0];
         r.contact_time = en < 0 ? en[31:0] : (st < 0 ? 32'd0 : st[31:0]);
         first = st < 0 ? 0 : st;
         r.hits_within_horizon = en >= 0 && first <= longint'(rq.time_horizon);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (contact_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", rsp_payload);
         end else begin
            want = contact_queue.pop_front();
            if (rsp_payload !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, rsp_payload);
            end
         end
      end
   end

   task automatic send_item(input req_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_payload <= rq;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      contact_queue.push_back(predict_contact(rq));
      @(negedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] val);
      start <= 1'b0;
      while (contact_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      tolerance = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pack3(input int x, input int y, input int z);
      return {CB'(z), CB'(y), CB'(x)};
   endfunction

   function automatic logic [WORD_W-1:0] near_vector(input int span);
      return pack3($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                   $urandom_range(0, 2*span) - span);
   endfunction

   function automatic req_type random_item();
      req_type rq;
      int kind, span;
      kind = $urandom_range(0, 9);
      span = kind < 4 ? 4000 : (kind < 7 ? 300 : 1 << 20);
      rq.first_position = near_vector(span);
      rq.second_position = near_vector(span);
      rq.first_velocity = near_vector(kind == 8 ? 0 : span);
      rq.second_velocity = kind == 8 ? rq.first_velocity ^ near_vector(1) : near_vector(span);
      rq.contact_distance = kind < 7 ? DIST_W'($urandom_range(0, 8 * span))
                                     : DIST_W'($urandom_range(0, 2097151));
      rq.time_horizon = $urandom_range(0, 1) ? HORIZON_W'($urandom_range(0, 1 << 20))
                                             : HORIZON_W'($urandom);
      if (kind == 9) begin
         rq.first_position = WORD_W'({$urandom, $urandom});
         rq.first_velocity = WORD_W'({$urandom, $urandom});
         rq.second_position = WORD_W'({$urandom, $urandom});
         rq.second_velocity = WORD_W'({$urandom, $urandom});
      end
      return rq;
   endfunction

   task automatic test_directed();
      req_type rq;
      rq = '0;
      send_item(rq);
      rq.contact_distance = 21'd256;
      send_item(rq);
      rq.first_position = pack3(1024, 0, 0);
      send_item(rq);
      rq.first_velocity = pack3(-256, 0, 0);
      rq.time_horizon = 31'h7FFFFFFF;
      send_item(rq);
      rq.first_velocity = pack3(256, 0, 0);
      send_item(rq);
      rq.first_velocity = pack3(0, 256, 0);
      send_item(rq);
      rq.first_position = pack3(0, 0, 0);
      rq.time_horizon = '0;
      send_item(rq);
      rq.first_position = {WORD_W{1'b1}};
      rq.second_position = pack3(-1048576, -1048576, -1048576);
      rq.first_velocity = pack3(1, 0, 0);
      rq.second_velocity = '0;
      rq.contact_distance = '0;
      send_item(rq);
      rq.first_position = pack3(1048575, 1048575, 1048575);
      rq.first_velocity = pack3(1048575, 1048575, 1048575);
      rq.second_velocity = pack3(-1048576, -1048576, -1048576);
      rq.contact_distance = 21'h1FFFFF;
      rq.time_horizon = 31'h7FFFFFFF;
      send_item(rq);
      rq = '0;
      rq.first_position = pack3(1, 0, 0);
      send_item(rq);
      rq.first_position = pack3(2, 0, 0);
      send_item(rq);
      rq.first_position = pack3(0, 0, 1);
      rq.first_velocity = pack3(0, 0, -1);
      rq.contact_distance = 21'd1;
      send_item(rq);
   endtask

   task automatic test_tolerance_sweep();
      write_tolerance(16'd0);
      test_directed();
      write_tolerance(16'hFFFF);
      test_directed();
   endtask

   task automatic test_random(input int count);
      repeat (count) send_item(random_item());
   endtask

   initial begin
      tolerance = 16'd1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_tolerance_sweep();
      write_tolerance(16'd1);
      test_random(500);
      write_tolerance(16'($urandom));
      test_random(500);
      write_tolerance(16'hFFFF);
      test_random(500);
      start <= 1'b0;
      while (contact_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (mismatches == 0) begin
         $display("swept_sphere_collision_interval_tb OK");
      end else begin
         $display("swept_sphere_collision_interval_tb NOT OK");
      end
      $finish;
   end

endmodule
